@@ design/dq_pkg.sv @@
// Shared types and constants for the double-ended queue.
// Used by dq_ctrl, dq_dp, double_ended_queue and tb_top; no dependencies.
`default_nettype none

package dq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    typedef enum logic [2:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_POP_BACK   = 3'd1,
        REQ_PUSH_FRONT = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_REVERSE    = 3'd4,
        REQ_CLEAR      = 3'd5
    } req_e_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_e_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_e_t;

    // controller -> datapath
    typedef struct packed {
        logic take_req;
        logic exec;
    } dq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_busy;
    } dq_stat_t;

endpackage

`default_nettype wire

@@ design/dq_ctrl.sv @@
// Request sequencer for the double-ended queue.
// Depends on dq_pkg for the state type and the command/status structs.
`default_nettype none

module dq_ctrl
    import dq_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire dq_stat_t stat,
    output dq_cmd_t       cmd
);

    state_e_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_EXEC;
            end
            S_EXEC: begin
                // wait until the result register can take the new item
                if (!stat.out_busy) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd.take_req = 1'b0;
        cmd.exec     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready     = 1'b1;
                cmd.take_req = s_tvalid;
            end
            S_EXEC: begin
                cmd.exec = !stat.out_busy;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

@@ design/dq_dp.sv @@
// Datapath of the double-ended queue: ring store, end pointers and result register.
// Depends on dq_pkg for request/status codes and the command/status structs.
`default_nettype none

module dq_dp
    import dq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF,
    localparam int ADDR_BITS = $clog2(DEPTH),
    localparam int CNT_BITS  = $clog2(DEPTH + 1)
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire dq_cmd_t                cmd,
    output dq_stat_t                    stat,
    input  wire logic [2:0]             req_type,
    input  wire logic [WORD_BITS-1:0]   push_value,
    input  wire logic                   m_tready,
    output logic                        m_valid,
    output logic [WORD_BITS-1:0]        popped_value,
    output logic [1:0]                  status,
    output logic [CNT_BITS-1:0]         entry_count
);

    localparam logic [ADDR_BITS:0]   DEPTH_W   = (ADDR_BITS + 1)'(DEPTH);
    localparam logic [ADDR_BITS-1:0] LAST_SLOT = ADDR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0]  FULL_CNT  = CNT_BITS'(DEPTH);

    logic [WORD_BITS-1:0] mem [DEPTH];

    logic [2:0]           req_reg;
    logic [WORD_BITS-1:0] val_reg;
    logic [ADDR_BITS-1:0] front_reg, front_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic                 rev_reg, rev_next;

    logic                 valid_reg;
    logic [WORD_BITS-1:0] popped_reg;
    logic [1:0]           status_reg;
    logic [CNT_BITS-1:0]  cnt_out_reg;

    logic                 is_push, high_end;
    logic                 do_write, do_read;
    logic [1:0]           status_next;
    logic [CNT_BITS-1:0]  offset;
    logic [ADDR_BITS:0]   high_sum;
    logic [ADDR_BITS-1:0] high_slot, low_push_slot, addr;

    always_ff @(posedge aclk) begin
        if (cmd.take_req) begin
            req_reg <= req_type;
            val_reg <= push_value;
        end
    end

    assign is_push = req_reg inside {REQ_PUSH_BACK, REQ_PUSH_FRONT};

    // slot at the high end: front + count for a push, front + count - 1 for a pop
    always_comb begin
        offset    = is_push ? count_reg : count_reg - CNT_BITS'(1);
        high_sum  = (ADDR_BITS + 1)'(front_reg) + (ADDR_BITS + 1)'(offset[ADDR_BITS-1:0]);
        high_slot = (high_sum >= DEPTH_W) ? ADDR_BITS'(high_sum - DEPTH_W)
                                          : high_sum[ADDR_BITS-1:0];
        low_push_slot = (front_reg == '0) ? LAST_SLOT : front_reg - ADDR_BITS'(1);
    end

    always_comb begin
        high_end    = 1'b0;
        front_next  = front_reg;
        count_next  = count_reg;
        rev_next    = rev_reg;
        status_next = ST_OK;
        do_write    = 1'b0;
        do_read     = 1'b0;
        addr        = high_slot;
        case (req_e_t'(req_reg))
            REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
                high_end = (req_reg == REQ_PUSH_BACK) ^ rev_reg;
                if (count_reg == FULL_CNT) begin
                    status_next = ST_FULL;
                end else begin
                    do_write   = 1'b1;
                    count_next = count_reg + CNT_BITS'(1);
                    if (!high_end) begin
                        addr       = low_push_slot;
                        front_next = low_push_slot;
                    end
                end
            end
            REQ_POP_BACK, REQ_POP_FRONT: begin
                high_end = (req_reg == REQ_POP_BACK) ^ rev_reg;
                if (count_reg == '0) begin
                    status_next = ST_EMPTY;
                end else begin
                    do_read    = 1'b1;
                    count_next = count_reg - CNT_BITS'(1);
                    if (!high_end) begin
                        addr       = front_reg;
                        front_next = (front_reg == LAST_SLOT) ? '0
                                                              : front_reg + ADDR_BITS'(1);
                    end
                end
            end
            REQ_REVERSE: rev_next = ~rev_reg;
            REQ_CLEAR: begin
                front_next = '0;
                count_next = '0;
                rev_next   = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
        end else if (cmd.exec) begin
            front_reg <= front_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && do_write) mem[addr] <= val_reg;
    end

    // registered read lands directly in the result register
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            popped_reg  <= do_read ? mem[addr] : '0;
            status_reg  <= status_next;
            cnt_out_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.exec) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    assign stat.out_busy = valid_reg && !m_tready;
    assign m_valid       = valid_reg;
    assign popped_value  = popped_reg;
    assign status        = status_reg;
    assign entry_count   = cnt_out_reg;

endmodule

`default_nettype wire

@@ design/double_ended_queue.sv @@
// Top level of the double-ended queue: stream ports, controller and datapath.
// Depends on dq_pkg, dq_ctrl and dq_dp.
//
//   channel | direction | tdata (low bit up)                 | tuser
//   s_      | in        | push_value                         | req_type
//   m_      | out       | popped_value, entry_count          | status
//
// A request is first taken into the request register; the update step then updates the ring
// and reads the store port into the result register.
// A result waiting in the output register does not block the next item being taken;
// the update step holds only while that register is still full.
// Reset (aresetn low, synchronous) empties the queue and clears the reverse flag.
// Store contents are not cleared.
`default_nettype none

module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF,
    localparam int CNT_BITS  = $clog2(DEPTH + 1),
    localparam int S_BYTES   = (WORD_BITS + 7) / 8,
    localparam int M_BYTES   = (WORD_BITS + CNT_BITS + 7) / 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_BYTES*8-1:0] s_tdata,   // push_value
    input  wire logic [2:0]           s_tuser,   // req_type
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_BYTES*8-1:0]      m_tdata,   // popped_value, entry_count
    output logic [1:0]                m_tuser    // status
);

    dq_cmd_t              cmd;
    dq_stat_t             stat;
    logic [WORD_BITS-1:0] popped_value;
    logic [CNT_BITS-1:0]  entry_count;

    dq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dq_dp #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (s_tuser),
        .push_value   (s_tdata[WORD_BITS-1:0]),
        .m_tready     (m_tready),
        .m_valid      (m_tvalid),
        .popped_value (popped_value),
        .status       (m_tuser),
        .entry_count  (entry_count)
    );

    assign m_tdata = (M_BYTES * 8)'({entry_count, popped_value});

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue: directed cases, fill/drain rounds
// and a long random mix, all checked against an in-bench deque predictor.
// Depends on dq_pkg and double_ended_queue.

module tb_top;
    import dq_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 20;

    // codes outside the request set; the block must ignore them
    localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

    localparam logic [31:0] WORD_MIN  = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX  = 32'h7fff_ffff;
    localparam logic [31:0] WORD_ZERO = 32'h0000_0000;
    localparam logic [31:0] WORD_ONES = 32'hffff_ffff;

    typedef struct {
        logic [31:0] popped;
        status_e_t   status;
        logic [4:0]  count;
    } dq_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;  // push_value
    logic [2:0]  s_tuser  = '0;  // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // popped_value, entry_count
    logic [1:0]  m_tuser;        // status

    // predictor state
    logic [31:0] dq_words [DEPTH];
    logic [3:0]  dq_head;
    logic [4:0]  dq_count;
    logic        dq_flipped;

    dq_result_t  expected_results[$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    int          ready_hold  = 0;
    bit          s_gaps_on   = 1'b0;
    bit          m_stalls_on = 1'b0;

    double_ended_queue u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic void clear_deque();
        dq_head    = '0;
        dq_count   = '0;
        dq_flipped = 1'b0;
    endfunction

    function automatic dq_result_t predict_request(logic [2:0] req, logic [31:0] value);
        dq_result_t res;
        logic       at_high;
        logic [3:0] slot;
        res.popped = '0;
        res.status = ST_OK;
        case (req)
            REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
                at_high = (req == REQ_PUSH_BACK) ^ dq_flipped;
                if (dq_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    if (at_high) begin
                        slot = dq_head + dq_count[3:0];
                        dq_words[slot] = value;
                    end else begin
                        dq_head = dq_head - 4'd1;
                        dq_words[dq_head] = value;
                    end
                    dq_count = dq_count + 5'd1;
                end
            end
            REQ_POP_BACK, REQ_POP_FRONT: begin
                at_high = (req == REQ_POP_BACK) ^ dq_flipped;
                if (dq_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    if (at_high) begin
                        // wraps correctly even with all slots held
                        slot = dq_head + dq_count[3:0] - 4'd1;
                        res.popped = dq_words[slot];
                    end else begin
                        res.popped = dq_words[dq_head];
                        dq_head = dq_head + 4'd1;
                    end
                    dq_count = dq_count - 5'd1;
                end
            end
            REQ_REVERSE: dq_flipped = ~dq_flipped;
            REQ_CLEAR:   clear_deque();
            default: ;
        endcase
        res.count = dq_count;
        return res;
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 11))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return WORD_ZERO;
            3:       return WORD_ONES;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: %s mismatch, got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    // Drive one item at the falling edge and hold it until the handshake.
    task automatic send_item(logic [2:0] req, logic [31:0] value);
        int gap;
        s_tuser  = req;
        s_tdata  = value;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(predict_request(req, value));
        @(negedge aclk);
        gap = pick_gap(s_gaps_on);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic send_push(bit at_back);
        send_item(at_back ? REQ_PUSH_BACK : REQ_PUSH_FRONT, random_word());
    endtask

    task automatic send_pop(bit at_back);
        send_item(at_back ? REQ_POP_BACK : REQ_POP_FRONT, $urandom);
    endtask

    task automatic test_directed();
        s_gaps_on   = 1'b0;
        m_stalls_on = 1'b0;
        send_pop(1'b1);                          // empty on both ends
        send_pop(1'b0);
        send_item(REQ_PUSH_BACK, WORD_MIN);
        send_item(REQ_PUSH_FRONT, WORD_MAX);
        send_item(REQ_PUSH_BACK, WORD_ZERO);
        send_item(REQ_PUSH_FRONT, WORD_ONES);
        send_pop(1'b0);
        send_item(REQ_REVERSE, $urandom);
        send_pop(1'b0);                          // front is now the old back
        send_item(REQ_PUSH_BACK, 32'h1234_5678);
        send_pop(1'b1);
        send_item(REQ_UNUSED_6, $urandom);
        send_item(REQ_UNUSED_7, $urandom);
        send_item(REQ_CLEAR, $urandom);
        send_pop(1'b0);
        send_item(REQ_REVERSE, $urandom);        // toggle on an empty queue
        send_item(REQ_PUSH_BACK, 32'h0000_0005);
        send_item(REQ_PUSH_FRONT, 32'h0000_0006);
        send_pop(1'b1);
        send_item(REQ_CLEAR, $urandom);
        send_pop(1'b1);
    endtask

    // Push past full, then pop past empty, mixing ends and reversals.
    task automatic test_fill_drain();
        for (int round = 0; round < 6; round++) begin
            s_gaps_on   = round[0];
            m_stalls_on = round[1];
            for (int i = 0; i < DEPTH + 3; i++) begin
                send_push(1'($urandom_range(0, 1)));
                if ($urandom_range(0, 7) == 0) send_item(REQ_REVERSE, $urandom);
            end
            for (int i = 0; i < DEPTH + 3; i++) begin
                send_pop(1'($urandom_range(0, 1)));
                if ($urandom_range(0, 7) == 0) send_item(REQ_REVERSE, $urandom);
            end
            if (round == 2) send_item(REQ_CLEAR, $urandom);
        end
    endtask

    task automatic send_random(bit grow);
        int r;
        int push_pct;
        r        = $urandom_range(0, 99);
        push_pct = grow ? 65 : 20;
        if (r < push_pct)
            send_push(1'($urandom_range(0, 1)));
        else if (r < 85)
            send_pop(1'($urandom_range(0, 1)));
        else if (r < 95)
            send_item(REQ_REVERSE, $urandom);
        else if (r < 98)
            send_item($urandom_range(0, 1) ? REQ_UNUSED_6 : REQ_UNUSED_7, $urandom);
        else
            send_item(REQ_CLEAR, $urandom);
    endtask

    task automatic test_random_mix();
        for (int chunk = 0; chunk < 36; chunk++) begin
            s_gaps_on   = 1'($urandom_range(0, 1));
            m_stalls_on = 1'($urandom_range(0, 1));
            for (int i = 0; i < 50; i++) send_random(chunk[0] == 1'b0);
            // hold off until the result path is empty
            if (chunk % 12 == 11) begin
                s_tvalid = 1'b0;
                wait (expected_results.size() == 0);
                @(negedge aclk);
            end
        end
    endtask

    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_tready   = 1'b0;
            ready_hold = ready_hold - 1;
        end else begin
            m_tready   = 1'b1;
            ready_hold = pick_gap(m_stalls_on);
        end
    end

    always @(posedge aclk) begin : check_results
        dq_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected item", m_tdata[31:0], '0);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[31:0] !== want.popped)
                    report_mismatch("popped_value", m_tdata[31:0], want.popped);
                if (m_tuser !== want.status)
                    report_mismatch("status", {30'd0, m_tuser}, {30'd0, want.status});
                if (m_tdata[36:32] !== want.count)
                    report_mismatch("entry_count", {27'd0, m_tdata[36:32]}, {27'd0, want.count});
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("double_ended_queue verification failed");
            $finish;
        end
    end

    initial begin
        clear_deque();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_fill_drain();
        test_random_mix();
        s_tvalid = 1'b0;
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("double_ended_queue verification clean");
        else
            $display("double_ended_queue verification failed");
        $finish;
    end

endmodule

@@ double_ended_queue.f @@
design/dq_pkg.sv
design/dq_ctrl.sv
design/dq_dp.sv
design/double_ended_queue.sv
test/tb_top.sv
